// ----- rtl/positional_char_list_core_macros.svh -----
// Assertion macros shared by the list core.
// Depends on nothing; users must have clock and reset in scope.
`ifndef POSITIONAL_CHAR_LIST_CORE_MACROS_SVH
`define POSITIONAL_CHAR_LIST_CORE_MACROS_SVH

// Condition holds on every edge out of reset.
`define PCL_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent on this edge implies consequent on the same edge.
`define PCL_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent on this edge implies consequent on the next edge.
`define PCL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pcl_pkg.sv -----
// Shared types and constants of the positional character list core.
// No dependencies.
package pcl_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int CMD_W      = 2;
   localparam int POS_W      = 7;
   localparam int CHAR_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_DEL   = 2'd1,
      CMD_GET   = 2'd2,
      CMD_PRINT = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_SHIFT,
      S_DEL_SHIFT,
      S_REPLY,
      S_PR_RD,
      S_PR_LD
   } state_type;

   // Control from the sequencer to the result register.
   typedef struct packed {
      logic       busy;
      logic       load;
      status_type status;
      logic       has_char;
      logic       last;
   } rsp_ctl_type;

endpackage

// ----- rtl/pcl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pcl_ctrl.sv -----
// Command sequencer: validates commands, shifts entries through the RAM,
// walks the store for print. Depends on pcl_pkg.
module pcl_ctrl #(
   parameter int CAPACITY = pcl_pkg::CAPACITY_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1),
   parameter int AW       = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  pcl_pkg::cmd_type             cmd,
   input  logic [pcl_pkg::POS_W-1:0]    position,
   input  logic [pcl_pkg::CHAR_W-1:0]   data_char,
   input  logic                         rsp_free,
   output pcl_pkg::rsp_ctl_type         ctl,
   output logic [CNT_W-1:0]             count,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [pcl_pkg::CHAR_W-1:0]   wr_data,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_addr,
   input  logic [pcl_pkg::CHAR_W-1:0]   rd_data
);
   import pcl_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  pos0_ff, pos0_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   status_type        rstatus_ff, rstatus_in;
   logic              rhas_ff, rhas_in;

   logic [7:0]        pos_ext, cnt_ext;
   logic [POS_W-1:0]  pos_m1;
   logic [CNT_W-1:0]  pos0, idx_up, idx_dn;
   logic              pos_nz, add_ok, full, in_range, pr_last;

   // command decode against the current fill
   always_comb begin
      pos_ext  = 8'(position);
      cnt_ext  = 8'(count_ff);
      pos_nz   = (position != '0);
      add_ok   = pos_nz && (pos_ext <= cnt_ext + 8'd1);
      in_range = pos_nz && (pos_ext <= cnt_ext);
      full     = (count_ff == CNT_W'(CAPACITY));
      pos_m1   = position - POS_W'(1);
      pos0     = pos_m1[CNT_W-1:0];
      idx_up   = idx_ff + CNT_W'(1);
      idx_dn   = idx_ff - CNT_W'(1);
      pr_last  = (idx_up == count_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (cmd)
                  CMD_ADD:   state_in = (add_ok && !full) ? S_ADD_SHIFT : S_REPLY;
                  CMD_DEL:   state_in = in_range ? S_DEL_SHIFT : S_REPLY;
                  CMD_GET:   state_in = S_REPLY;
                  CMD_PRINT: state_in = (count_ff == '0) ? S_REPLY : S_PR_RD;
                  default:   state_in = S_REPLY;
               endcase
            end
         end
         S_ADD_SHIFT: begin
            if (idx_ff == pos0_ff && !pend_ff) state_in = S_REPLY;
         end
         S_DEL_SHIFT: begin
            if (idx_ff == count_ff && !pend_ff) state_in = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_free) state_in = S_IDLE;
         end
         S_PR_RD: begin
            if (rsp_free) state_in = S_PR_LD;
         end
         S_PR_LD: begin
            state_in = pr_last ? S_IDLE : S_PR_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos0_in      = pos0_ff;
      char_in      = char_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rstatus_in   = rstatus_ff;
      rhas_in      = rhas_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos0_in    = pos0;
               char_in    = data_char;
               pend_in    = 1'b0;
               rhas_in    = 1'b0;
               rstatus_in = ST_OK;
               case (cmd)
                  CMD_ADD: begin
                     idx_in     = count_ff;
                     rstatus_in = !add_ok ? ST_BADPOS : (full ? ST_FULL : ST_OK);
                  end
                  CMD_DEL: begin
                     idx_in     = pos0 + CNT_W'(1);
                     rstatus_in = in_range ? ST_OK : ST_BADPOS;
                  end
                  CMD_GET: begin
                     rstatus_in = in_range ? ST_OK : ST_BADPOS;
                     rhas_in    = in_range;
                  end
                  default: begin
                     idx_in = '0;
                  end
               endcase
            end
         end
         S_ADD_SHIFT: begin
            if (idx_ff != pos0_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
               idx_in       = idx_dn;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         S_DEL_SHIFT: begin
            if (idx_ff != count_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = idx_dn[AW-1:0];
               idx_in       = idx_up;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         S_PR_LD: begin
            idx_in = idx_up;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // RAM port and result control
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      ctl.busy     = (state_ff != S_IDLE);
      ctl.load     = 1'b0;
      ctl.status   = rstatus_ff;
      ctl.has_char = rhas_ff;
      ctl.last     = 1'b1;
      case (state_ff)
         S_IDLE: begin
            rd_en   = req_valid && (cmd == CMD_GET) && in_range;
            rd_addr = pos0[AW-1:0];
         end
         S_ADD_SHIFT: begin
            wr_en = pend_ff;
            if (idx_ff != pos0_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_dn[AW-1:0];
            end else if (!pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos0_ff[AW-1:0];
               wr_data = char_ff;
            end
         end
         S_DEL_SHIFT: begin
            wr_en = pend_ff;
            if (idx_ff != count_ff) begin
               rd_en = 1'b1;
            end
         end
         S_REPLY: begin
            ctl.load = rsp_free;
         end
         S_PR_RD: begin
            rd_en = rsp_free;
         end
         S_PR_LD: begin
            ctl.load     = 1'b1;
            ctl.status   = ST_OK;
            ctl.has_char = 1'b1;
            ctl.last     = pr_last;
         end
         default: begin
            ctl.load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      idx_ff       <= idx_in;
      pos0_ff      <= pos0_in;
      char_ff      <= char_in;
      pend_addr_ff <= pend_addr_in;
      rstatus_ff   <= rstatus_in;
      rhas_ff      <= rhas_in;
   end

   assign count = count_ff;

endmodule

// ----- rtl/positional_char_list_core.sv -----
// Top level of the positional character list core: stream ports, result
// register, sequencer and character RAM. Depends on pcl_pkg, pcl_ctrl,
// pcl_ram and positional_char_list_core_macros.svh.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------
//   req_    | in  | one command: add, delete, get or print
//   rsp_    | out | status, optional character; tlast on final beat
//
// Get, bad positions, a full store and empty print go straight to the reply.
// Add moves (count - position + 1) entries, delete (count - position), one
// per cycle through the RAM port; add then writes the new character.
// Print reads each entry once the rsp_ slot is free, then loads it as a beat.
// Reset clears the fill count and control; RAM contents are left as is.
// A stalled rsp_ holds its beat; a new command waits until the last is loaded.
`include "positional_char_list_core_macros.svh"

module positional_char_list_core #(
   parameter int CAPACITY = pcl_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] cmd, [8:2] position, [16:9] data_char, [23:17] zero
   input  logic [pcl_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] status, [9:2] out_char, [15:10] zero
   output logic [pcl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] has_char
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);
   import pcl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);

   cmd_type           req_cmd;
   logic [POS_W-1:0]  req_position;
   logic [CHAR_W-1:0] req_char;

   rsp_ctl_type       ctl;
   logic [CNT_W-1:0]  count;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;
   logic              rsp_free;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_last_ff, rsp_last_in;

   assign req_cmd      = cmd_type'(req_tdata[1:0]);
   assign req_position = req_tdata[8:2];
   assign req_char     = req_tdata[16:9];
   assign req_tready   = !ctl.busy;

   // slot is free when empty or draining this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   pcl_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .AW       (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .cmd       (req_cmd),
      .position  (req_position),
      .data_char (req_char),
      .rsp_free  (rsp_free),
      .ctl       (ctl),
      .count     (count),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   pcl_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctl.load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ctl.status;
         // RAM read data holds the character for get and print
         rsp_char_in   = ctl.has_char ? rd_data : '0;
         rsp_has_in    = ctl.has_char;
         rsp_last_in   = ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_char_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

   // fill count never exceeds the store
   `PCL_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY), "fill count above capacity")
   // a result is only loaded into a free or draining slot
   `PCL_ASSERT_SAME(a_load_free, ctl.load, rsp_free, "result overwrites pending beat")
   // an accepted command always occupies the sequencer next cycle
   `PCL_ASSERT_NEXT(a_accept_busy, req_tvalid && req_tready, ctl.busy, "command dropped")

endmodule
